>>> hw/rtl/aoc_pkg.sv
// Shared types and constants of the alarm occurrence controller.
// Used by the controller top level, its table unit and its port checker.
package aoc_pkg;

	localparam int unsigned REQ_W      = 3;
	localparam int unsigned STATUS_W   = 4;
	localparam int unsigned S_TDATA_W  = 320;
	localparam int unsigned M_TDATA_W  = 160;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 20;

	// Request kinds carried in the slave-side tuser.
	localparam logic [REQ_W-1:0] REQ_EVAL    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_SNOOZE  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_TICK    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DISMISS = 3'd3;
	localparam logic [REQ_W-1:0] REQ_RECOVER = 3'd4;

	// Result status codes carried in the master-side tuser.
	localparam logic [STATUS_W-1:0] STS_NONE      = 4'd0;
	localparam logic [STATUS_W-1:0] STS_DISABLED  = 4'd1;
	localparam logic [STATUS_W-1:0] STS_BAD_TIME  = 4'd2;
	localparam logic [STATUS_W-1:0] STS_CONFLICT  = 4'd3;
	localparam logic [STATUS_W-1:0] STS_DUPLICATE = 4'd4;
	localparam logic [STATUS_W-1:0] STS_MISSED    = 4'd5;
	localparam logic [STATUS_W-1:0] STS_RINGING   = 4'd6;
	localparam logic [STATUS_W-1:0] STS_BAD_REQ   = 4'd7;
	localparam logic [STATUS_W-1:0] STS_LIMIT     = 4'd8;
	localparam logic [STATUS_W-1:0] STS_SNOOZED   = 4'd9;
	localparam logic [STATUS_W-1:0] STS_TIMED_OUT = 4'd10;
	localparam logic [STATUS_W-1:0] STS_DISMISSED = 4'd11;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LATE_GRACE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SNOOZE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SNOOZE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME   = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_CALC   = 4'b0010,
		S_SCAN   = 4'b0100,
		S_DECIDE = 4'b1000
	} fsm_t;

	typedef struct packed {
		logic [7:0]  alarm;
		logic [15:0] rev;
		logic [63:0] sched;
	} okey_t;

	typedef struct packed {
		logic [7:0]  alarm;
		logic [63:0] mark;
	} mark_ent_t;

	// Write requests from the controller to the table unit.
	typedef struct packed {
		logic mark;
		logic recent;
	} tbl_wr_t;

	// Search results of the table unit.
	typedef struct packed {
		logic        done;
		logic        mark_hit;
		logic [63:0] mark_val;
		logic        mark_free;
		logic        recent_hit;
	} tbl_res_t;

endpackage

>>> hw/rtl/aoc_tables.sv
// Watermark table and recent-key ring of the alarm occurrence controller.
// Both live in synchronous memories scanned one entry per cycle. Depends on aoc_pkg.
module aoc_tables #(
	parameter int MARK_ENTRIES   = 16,
	parameter int RECENT_ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             scan_start,
	input  aoc_pkg::okey_t   key,
	input  aoc_pkg::tbl_wr_t wr,
	output aoc_pkg::tbl_res_t res
);
	import aoc_pkg::*;

	localparam int SCAN_N = (MARK_ENTRIES > RECENT_ENTRIES) ? MARK_ENTRIES : RECENT_ENTRIES;
	localparam int MW     = (MARK_ENTRIES > 1) ? $clog2(MARK_ENTRIES) : 1;
	localparam int RW     = (RECENT_ENTRIES > 1) ? $clog2(RECENT_ENTRIES) : 1;
	localparam int CW     = $clog2(SCAN_N + 1);
	localparam int RCW    = $clog2(RECENT_ENTRIES + 1);

	mark_ent_t mark_mem [MARK_ENTRIES];
	okey_t     rec_mem  [RECENT_ENTRIES];
	mark_ent_t mark_rd_s1;
	okey_t     rec_rd_s1;

	logic [MARK_ENTRIES-1:0]   mark_vld_q;
	logic [RECENT_ENTRIES-1:0] rec_vld_q;
	logic [RCW-1:0]            rec_cnt_q;
	logic [RW-1:0]             rec_head_q;

	logic          busy_q, done_q, cmp_s1;
	logic [CW-1:0] cnt_q, idx_s1;

	logic          mark_hit_q, free_q, rec_hit_q;
	logic [MW-1:0] mark_idx_q, free_idx_q;
	logic [63:0]   mark_val_q;

	logic          m_rd_ok, r_rd_ok, m_cmp_ok, r_cmp_ok;
	logic [MW-1:0] mark_raddr, mark_waddr, m_ci;
	logic [RW-1:0] rec_raddr, rec_waddr, r_ci;
	logic          mark_we, mark_new, rec_we, rec_full;

	always_comb begin
		m_rd_ok    = cnt_q < CW'(MARK_ENTRIES);
		r_rd_ok    = cnt_q < CW'(RECENT_ENTRIES);
		mark_raddr = m_rd_ok ? cnt_q[MW-1:0] : '0;
		rec_raddr  = r_rd_ok ? cnt_q[RW-1:0] : '0;
		m_cmp_ok   = cmp_s1 && (idx_s1 < CW'(MARK_ENTRIES));
		r_cmp_ok   = cmp_s1 && (idx_s1 < CW'(RECENT_ENTRIES));
		m_ci       = m_cmp_ok ? idx_s1[MW-1:0] : '0;
		r_ci       = r_cmp_ok ? idx_s1[RW-1:0] : '0;
		// A known alarm only ever moves its watermark up.
		if (mark_hit_q) begin
			mark_we    = wr.mark && ($signed(key.sched) > $signed(mark_val_q));
			mark_new   = 1'b0;
			mark_waddr = mark_idx_q;
		end else begin
			mark_we    = wr.mark && free_q;
			mark_new   = mark_we;
			mark_waddr = free_idx_q;
		end
		rec_full  = rec_cnt_q == RCW'(RECENT_ENTRIES);
		rec_we    = wr.recent && !rec_hit_q;
		// Once full, the oldest entry sits at the head and is overwritten.
		rec_waddr = rec_full ? rec_head_q : rec_cnt_q[RW-1:0];
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_waddr] <= '{alarm: key.alarm, mark: key.sched};
		end
		if (rec_we) begin
			rec_mem[rec_waddr] <= key;
		end
		mark_rd_s1 <= mark_mem[mark_raddr];
		rec_rd_s1  <= rec_mem[rec_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			cmp_s1     <= 1'b0;
			cnt_q      <= '0;
			idx_s1     <= '0;
			mark_hit_q <= 1'b0;
			free_q     <= 1'b0;
			rec_hit_q  <= 1'b0;
			mark_idx_q <= '0;
			free_idx_q <= '0;
			mark_val_q <= '0;
			mark_vld_q <= '0;
			rec_vld_q  <= '0;
			rec_cnt_q  <= '0;
			rec_head_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (scan_start) begin
				busy_q     <= 1'b1;
				cnt_q      <= '0;
				cmp_s1     <= 1'b0;
				mark_hit_q <= 1'b0;
				free_q     <= 1'b0;
				rec_hit_q  <= 1'b0;
			end else if (busy_q) begin
				if (cnt_q < CW'(SCAN_N)) begin
					cmp_s1 <= 1'b1;
					idx_s1 <= cnt_q;
					cnt_q  <= cnt_q + 1'b1;
				end else begin
					cmp_s1 <= 1'b0;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
			if (m_cmp_ok) begin
				if (mark_vld_q[m_ci] && mark_rd_s1.alarm == key.alarm && !mark_hit_q) begin
					mark_hit_q <= 1'b1;
					mark_idx_q <= m_ci;
					mark_val_q <= mark_rd_s1.mark;
				end else if (!mark_vld_q[m_ci] && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= m_ci;
				end
			end
			if (r_cmp_ok && rec_vld_q[r_ci] && rec_rd_s1 == key) begin
				rec_hit_q <= 1'b1;
			end
			if (mark_new) begin
				mark_vld_q[mark_waddr] <= 1'b1;
			end
			if (rec_we) begin
				rec_vld_q[rec_waddr] <= 1'b1;
				if (rec_full) begin
					rec_head_q <= (rec_head_q == RW'(RECENT_ENTRIES - 1)) ? '0 :
						rec_head_q + 1'b1;
				end else begin
					rec_cnt_q <= rec_cnt_q + 1'b1;
				end
			end
		end
	end

	assign res = '{done: done_q, mark_hit: mark_hit_q, mark_val: mark_val_q,
		mark_free: free_q, recent_hit: rec_hit_q};

endmodule

>>> hw/rtl/alarm_occurrence_controller.sv
// Top level of the alarm occurrence controller: request decoding, occurrence state,
// time arithmetic and result register. Depends on aoc_pkg and aoc_tables.
//
// The controller handles one request transaction at a time and returns exactly one result
// transaction for each. A request passes the calculation, scan and decision states, and
// then its result is registered; in the scan the table unit walks the watermark memory
// and the recent-key memory side by side, one entry per cycle, each through its single
// read port. The next request is accepted once the decision is made, while the previous
// result may still wait in the output register. The active occurrence lives in flip-flops;
// the two tables live in memories whose valid bits are cleared by reset, so no clearing
// pass is needed. A table is written only in the decision cycle and never while it is
// scanned, so no forwarding is required. Configuration writes are always accepted and take
// effect on the next request; write them only while no request is in flight. Indexes past
// the last register are ignored.
module alarm_occurrence_controller #(
	parameter int MARK_ENTRIES   = 16,
	parameter int RECENT_ENTRIES = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// alarm_index, revision, scheduled_time, alarm_enabled, wall clock trusted flag,
	// wall_time, mono_time, snooze_duration, dismiss_by_disable, boot_number, zero fill
	input  logic [aoc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	// req_type
	input  logic [aoc_pkg::REQ_W-1:0]        s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// out_alarm_index, out_revision, out_scheduled_time, key_valid, alert begin,
	// alert end, persist_first, late_flag, lateness, recovered, zero fill
	output logic [aoc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	// status
	output logic [aoc_pkg::STATUS_W-1:0]     m_axis_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [aoc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [aoc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import aoc_pkg::*;

	fsm_t state_q;

	// Configuration registers.
	logic [16:0] grace_q, min_snz_q, max_snz_q;
	logic [7:0]  max_cnt_q;
	logic [19:0] life_q;

	// Captured request. The dismiss_by_disable bit has no effect and is not kept.
	logic [REQ_W-1:0] type_q;
	okey_t            in_key_q;
	logic             en_q, tv_q;
	logic [63:0]      wall_q, mono_q, dur_q;
	logic [31:0]      boot_q;

	// Active occurrence.
	logic        act_vld_q, dl_vld_q, boot_vld_q;
	okey_t       act_key_q;
	logic [63:0] frw_q, frm_q, dl_q;
	logic [7:0]  snz_cnt_q;
	logic [31:0] boot_last_q;

	// Arithmetic results, computed once per request.
	logic        span_ok_q, sum_ok_q, mono_lt_frm_q, mono_lt_dl_q, dur_lt_q, dur_gt_q;
	logic [62:0] span_e_q;
	logic [63:0] sum_q;

	// Result register.
	logic                  out_vld_q;
	logic [STATUS_W-1:0]   out_user_q;
	logic [M_TDATA_W-1:0]  out_data_q;

	logic [63:0] span_now, span_start, sum_r;
	logic [64:0] span_d;

	tbl_wr_t  tbl_wr;
	tbl_res_t tbl_res;
	okey_t    srch_key;
	logic     scan_start, fire, act_match;

	logic [STATUS_W-1:0] sts;
	okey_t               o_key;
	logic                kv, start, stop, persist, late, rec;
	logic [62:0]         late_e;
	logic                do_ring, do_finish, do_missed, do_snooze, do_wake, do_recover;

	assign s_axis_tready = state_q == S_IDLE;
	assign cfg_ready     = 1'b1;
	assign scan_start    = state_q == S_CALC;
	assign fire          = (state_q == S_DECIDE) && (!out_vld_q || m_axis_tready);
	assign act_match     = act_vld_q && (in_key_q == act_key_q);
	// Evaluation looks up the requested key; tick, dismiss and recovery requests may retire the active one.
	assign srch_key      = (type_q == REQ_EVAL) ? in_key_q : act_key_q;

	assign tbl_wr.mark   = fire && (do_missed || do_finish);
	assign tbl_wr.recent = fire && (do_missed || do_finish);

	aoc_tables #(
		.MARK_ENTRIES   (MARK_ENTRIES),
		.RECENT_ENTRIES (RECENT_ENTRIES)
	) u_tables (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan_start (scan_start),
		.key        (srch_key),
		.wr         (tbl_wr),
		.res        (tbl_res)
	);

	// Elapsed-time operands depend on the request kind.
	always_comb begin
		case (type_q)
			REQ_TICK: begin
				span_now   = mono_q;
				span_start = frm_q;
			end
			REQ_RECOVER: begin
				span_now   = wall_q;
				span_start = frw_q;
			end
			default: begin
				span_now   = wall_q;
				span_start = in_key_q.sched;
			end
		endcase
		span_d = {span_now[63], span_now} - {span_start[63], span_start};
		sum_r  = mono_q + dur_q;
	end

	// Decision for the current request, from the scan results and the arithmetic flags.
	always_comb begin
		sts        = STS_NONE;
		kv         = 1'b0;
		o_key      = in_key_q;
		start      = 1'b0;
		stop       = 1'b0;
		persist    = 1'b0;
		late       = 1'b0;
		rec        = 1'b0;
		late_e     = '0;
		do_ring    = 1'b0;
		do_finish  = 1'b0;
		do_missed  = 1'b0;
		do_snooze  = 1'b0;
		do_wake    = 1'b0;
		do_recover = 1'b0;
		case (type_q)
			REQ_EVAL: begin
				if (!en_q) begin
					sts = STS_DISABLED;
				end else if (!tv_q) begin
					sts = STS_BAD_TIME;
				end else if ($signed(wall_q) < $signed(in_key_q.sched)) begin
					sts = STS_NONE;
				end else begin
					kv = 1'b1;
					if (act_vld_q && !act_match) begin
						sts = STS_CONFLICT;
					end else if (act_vld_q || tbl_res.recent_hit || (tbl_res.mark_hit &&
						$signed(in_key_q.sched) <= $signed(tbl_res.mark_val))) begin
						sts = STS_DUPLICATE;
					end else if (!tbl_res.mark_hit && !tbl_res.mark_free) begin
						sts = STS_CONFLICT;
					end else if (!span_ok_q) begin
						sts = STS_BAD_TIME;
					end else if (span_e_q > 63'(grace_q)) begin
						sts       = STS_MISSED;
						persist   = 1'b1;
						late_e    = span_e_q;
						do_missed = 1'b1;
					end else begin
						sts     = STS_RINGING;
						start   = 1'b1;
						persist = 1'b1;
						late    = span_e_q != '0;
						late_e  = span_e_q;
						do_ring = 1'b1;
					end
				end
			end
			REQ_SNOOZE: begin
				kv = 1'b1;
				if (!act_match || dl_vld_q) begin
					sts = STS_CONFLICT;
				end else if (dur_lt_q || dur_gt_q) begin
					sts = STS_BAD_REQ;
				end else if (snz_cnt_q >= max_cnt_q) begin
					sts = STS_LIMIT;
				end else if (mono_lt_frm_q || !sum_ok_q) begin
					sts = STS_BAD_TIME;
				end else begin
					sts       = STS_SNOOZED;
					stop      = 1'b1;
					persist   = 1'b1;
					do_snooze = 1'b1;
				end
			end
			REQ_TICK: begin
				if (act_vld_q) begin
					kv    = 1'b1;
					o_key = act_key_q;
					if (!span_ok_q) begin
						sts = STS_BAD_TIME;
					end else if (span_e_q >= 63'(life_q)) begin
						sts       = STS_TIMED_OUT;
						stop      = 1'b1;
						persist   = 1'b1;
						do_finish = 1'b1;
					end else if (!dl_vld_q) begin
						sts = STS_RINGING;
					end else if (mono_lt_dl_q) begin
						sts = STS_SNOOZED;
					end else begin
						sts     = STS_RINGING;
						start   = 1'b1;
						persist = 1'b1;
						do_wake = 1'b1;
					end
				end
			end
			REQ_DISMISS: begin
				kv = 1'b1;
				if (!act_match) begin
					sts = STS_CONFLICT;
				end else begin
					sts       = STS_DISMISSED;
					stop      = 1'b1;
					persist   = 1'b1;
					do_finish = 1'b1;
				end
			end
			REQ_RECOVER: begin
				if (act_vld_q) begin
					kv    = 1'b1;
					o_key = act_key_q;
					if (boot_vld_q && boot_last_q == boot_q) begin
						sts = STS_DUPLICATE;
					end else if (!span_ok_q) begin
						sts = STS_BAD_TIME;
					end else if (span_e_q >= 63'(life_q)) begin
						sts       = STS_MISSED;
						persist   = 1'b1;
						do_finish = 1'b1;
					end else begin
						sts        = STS_RINGING;
						start      = 1'b1;
						persist    = 1'b1;
						rec        = 1'b1;
						do_recover = 1'b1;
					end
				end
			end
			default: begin
				sts = STS_BAD_REQ;
			end
		endcase
		if (!kv) begin
			o_key = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grace_q   <= 17'd600;
			min_snz_q <= 17'd60;
			max_snz_q <= 17'd3600;
			max_cnt_q <= 8'd3;
			life_q    <= 20'd3600;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LATE_GRACE: grace_q   <= cfg_data[16:0];
				CFG_MIN_SNOOZE: min_snz_q <= cfg_data[16:0];
				CFG_MAX_SNOOZE: max_snz_q <= cfg_data[16:0];
				CFG_MAX_COUNT:  max_cnt_q <= cfg_data[7:0];
				CFG_LIFETIME:   life_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Request capture, arithmetic stage and result register load.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			type_q         <= s_axis_tuser;
			in_key_q.alarm <= s_axis_tdata[7:0];
			in_key_q.rev   <= s_axis_tdata[23:8];
			in_key_q.sched <= s_axis_tdata[87:24];
			en_q           <= s_axis_tdata[88];
			tv_q           <= s_axis_tdata[89];
			wall_q         <= s_axis_tdata[153:90];
			mono_q         <= s_axis_tdata[217:154];
			dur_q          <= s_axis_tdata[281:218];
			boot_q         <= s_axis_tdata[314:283];
		end
		if (state_q == S_CALC) begin
			// The span must be non-negative and fit in a signed 64-bit value.
			span_ok_q     <= !span_d[64] && !span_d[63];
			span_e_q      <= span_d[62:0];
			sum_ok_q      <= !((mono_q[63] == dur_q[63]) && (sum_r[63] != mono_q[63]));
			sum_q         <= sum_r;
			mono_lt_frm_q <= $signed(mono_q) < $signed(frm_q);
			mono_lt_dl_q  <= $signed(mono_q) < $signed(dl_q);
			dur_lt_q      <= $signed(dur_q) < $signed({47'd0, min_snz_q});
			dur_gt_q      <= $signed(dur_q) > $signed({47'd0, max_snz_q});
		end
		if (fire) begin
			out_user_q <= sts;
			out_data_q <= {3'd0, rec, late_e, late, persist, stop, start, kv,
				o_key.sched, o_key.rev, o_key.alarm};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_vld_q   <= 1'b0;
			act_vld_q   <= 1'b0;
			act_key_q   <= '0;
			frw_q       <= '0;
			frm_q       <= '0;
			snz_cnt_q   <= '0;
			dl_vld_q    <= 1'b0;
			dl_q        <= '0;
			boot_vld_q  <= 1'b0;
			boot_last_q <= '0;
		end else begin
			if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (tbl_res.done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (fire) begin
						state_q   <= S_IDLE;
						out_vld_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (fire) begin
				if (do_ring || do_finish) begin
					// A new occurrence starts clean; a finished one leaves nothing behind.
					act_vld_q   <= do_ring;
					act_key_q   <= do_ring ? in_key_q : '0;
					frw_q       <= do_ring ? wall_q : '0;
					frm_q       <= do_ring ? mono_q : '0;
					snz_cnt_q   <= '0;
					dl_vld_q    <= 1'b0;
					dl_q        <= '0;
					boot_vld_q  <= 1'b0;
					boot_last_q <= '0;
				end
				if (do_snooze) begin
					snz_cnt_q <= snz_cnt_q + 1'b1;
					dl_vld_q  <= 1'b1;
					dl_q      <= sum_q;
				end
				if (do_wake || do_recover) begin
					dl_vld_q <= 1'b0;
					dl_q     <= '0;
				end
				if (do_recover) begin
					boot_vld_q  <= 1'b1;
					boot_last_q <= boot_q;
				end
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tdata  = out_data_q;

endmodule

>>> hw/rtl/aoc_checker.sv
// Port-level checks of the alarm occurrence controller, bound to its top level.
// Depends on aoc_pkg and alarm_occurrence_controller.
module aoc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [aoc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	input logic [aoc_pkg::STATUS_W-1:0]   m_axis_tuser
);
	import aoc_pkg::*;

	// A result transaction held back by the sink stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result withdrawn while stalled");

	// Without a key, the key fields read as zero.
	a_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[88] |-> m_axis_tdata[87:0] == '0)
		else $error("key fields set without key_valid");

	// A result never both starts and stops the alert.
	a_start_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[89] && m_axis_tdata[90]))
		else $error("start and stop alert together");

	// A recovery result always resumes ringing.
	a_recovered: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[156] |->
			m_axis_tuser == STS_RINGING && m_axis_tdata[89])
		else $error("recovered without ringing");

	// A result is registered only in the decision state, never right after acceptance.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("result too soon after request");

endmodule

bind alarm_occurrence_controller aoc_checker u_aoc_checker (.*);
